// ===== rtl/srs_pkg.sv =====
package srs_pkg;

    localparam int ID_W              = 16;
    localparam int ACK_W             = 17;
    localparam int SEQ_W             = 32;
    localparam int ID_SPACE          = 65536;
    localparam int OUT_LIMIT         = 32;
    localparam int ROW_BITS          = 32;
    localparam int ROW_IW            = 5;
    localparam int DEF_MAX_PACKETS   = 65536;
    localparam int DEF_NAK_LIST_SIZE = 32;

    typedef enum logic {
        ACT_ARRIVAL = 1'b0,
        ACT_TICK    = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_NAK    = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_BELOW  = 2'd0,
        ST_HELD   = 2'd1,
        ST_STORED = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHK,
        S_ADV_RD,
        S_ADV_CHK,
        S_A_OUT,
        S_END_OUT,
        S_N_RD,
        S_N_SRCH,
        S_N_END,
        S_L2
    } state_t;

    typedef struct packed {
        kind_t              kind;
        status_t            status;
        logic [ACK_W-1:0]   ack_no;
        logic [ID_W-1:0]    nak_id;
        logic [SEQ_W-1:0]   msg_seq;
        logic               last;
        logic               done_res;
    } rsp_t;

    function automatic logic [ROW_BITS-1:0] low_mask(input logic [ROW_IW-1:0] off);
        return (ROW_BITS'(1) << off) - ROW_BITS'(1);
    endfunction

    function automatic logic [ROW_IW:0] first_one(input logic [ROW_BITS-1:0] v);
        logic [ROW_IW:0] pos;
        pos = (ROW_IW + 1)'(ROW_BITS);
        for (int k = ROW_BITS - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                pos = (ROW_IW + 1)'(k);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/srs_req_if.sv =====
interface srs_req_if;
    import srs_pkg::*;

    logic            valid;
    logic            ready;
    logic            action;
    logic [ID_W-1:0] packet_id;

    modport source (output valid, action, packet_id, input ready);
    modport sink (input valid, action, packet_id, output ready);
endinterface

// ===== rtl/srs_rsp_if.sv =====
interface srs_rsp_if;
    import srs_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [1:0]       arrival_status;
    logic [ACK_W-1:0] ack_no;
    logic [ID_W-1:0]  nak_id;
    logic [SEQ_W-1:0] msg_seq;
    logic             last;
    logic             done_res;

    modport source (output valid, kind, arrival_status, ack_no, nak_id, msg_seq, last,
                    done_res, input ready);
    modport sink (input valid, kind, arrival_status, ack_no, nak_id, msg_seq, last,
                  done_res, output ready);
endinterface

// ===== rtl/srs_ram.sv =====
module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/selective_repeat_receive_scoreboard_core.sv =====
// Receive scoreboard for a NAK-based selective-repeat transfer. The received bitmap lives
// in one RAM of 32-bit rows; after reset a clearing pass writes every row, that is
// min(MAX_PACKETS, 65536)/32 rows rounded up (2048 by default), and no request is taken
// until it ends. An arrival request returns one status result: a drop below the window or
// beyond the bitmap needs no RAM read, any other arrival reads its bitmap row, and a stored
// arrival then reads bitmap rows while the expected id advances, at least one.
// A tick request after done returns one end acknowledgement. Any other tick scans
// the rows from the expected id up to the highest held id and emits one NAK entry per gap
// found, and when no gap is found falls back to listing each id from the expected id.
// The bitmap RAM has a single read port. Results leave through an output register, so a
// waiting result does not block the next request.
module selective_repeat_receive_scoreboard_core #(
    parameter int MAX_PACKETS   = srs_pkg::DEF_MAX_PACKETS,
    parameter int NAK_LIST_SIZE = srs_pkg::DEF_NAK_LIST_SIZE
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [srs_pkg::ACK_W-1:0] cfg_wr_data,
    srs_req_if.sink                  request,
    srs_rsp_if.source                result
);
    import srs_pkg::*;

    localparam int MAP_IDS = (MAX_PACKETS < ID_SPACE) ? MAX_PACKETS : ID_SPACE;
    localparam int ROWS    = (MAP_IDS + ROW_BITS - 1) / ROW_BITS;
    localparam int RA      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CAP     = (NAK_LIST_SIZE < OUT_LIMIT) ? NAK_LIST_SIZE : OUT_LIMIT;
    localparam int CNT_W   = $clog2(CAP + 1);
    localparam logic [ACK_W-1:0] MAP_LIM = ACK_W'(MAP_IDS);

    state_t               state_reg, state_next;
    logic [RA-1:0]        clr_reg, clr_next;
    logic [ID_W-1:0]      pid_reg, pid_next;
    status_t              status_reg, status_next;
    logic [ACK_W-1:0]     exp_reg, exp_next;
    logic [ACK_W-1:0]     idx_reg, idx_next;
    logic [ACK_W-1:0]     total_reg;
    logic [ID_W-1:0]      high_reg, high_next;
    logic [ID_W-1:0]      hold_reg, hold_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic                 done_reg, done_next;
    logic [SEQ_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 res_valid_reg;
    rsp_t                 res_reg;

    logic                 push;
    rsp_t                 push_data;
    logic                 accept;
    logic                 out_free;
    logic [ACK_W-1:0]     lim;
    logic [ACK_W-1:0]     req_id;
    logic [ACK_W-1:0]     pid_id;
    logic [ACK_W-1:0]     high_id;
    logic [CNT_W-1:0]     n_inc;
    logic                 cap_hit;

    logic                 ram_we;
    logic                 ram_re;
    logic [RA-1:0]        ram_waddr;
    logic [RA-1:0]        ram_raddr;
    logic [ROW_BITS-1:0]  ram_wdata;
    logic [ROW_BITS-1:0]  ram_rdata;

    logic                 chk_held;
    logic [ROW_BITS-1:0]  adv_mask;
    logic [ROW_IW:0]      adv_z;
    logic [ACK_W-1:0]     adv_cand;
    logic [ACK_W-1:0]     adv_new;
    logic [ACK_W-1:0]     sc_base;
    logic [ROW_BITS-1:0]  sc_lt;
    logic [ROW_BITS-1:0]  sc_cand;
    logic [ROW_IW:0]      sc_f;
    logic                 sc_found;
    logic [ACK_W-1:0]     sc_id;
    logic                 l2_last;

    srs_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign out_free      = !res_valid_reg || result.ready;
    assign lim           = (total_reg < MAP_LIM) ? total_reg : MAP_LIM;
    assign req_id        = {1'b0, request.packet_id};
    assign pid_id        = {1'b0, pid_reg};
    assign high_id       = {1'b0, high_reg};
    assign n_inc         = n_reg + 1'b1;
    assign cap_hit       = (n_inc == CNT_W'(CAP));

    assign chk_held = ram_rdata[pid_reg[ROW_IW-1:0]];

    assign adv_mask = ram_rdata | low_mask(exp_reg[ROW_IW-1:0]);
    assign adv_z    = first_one(~adv_mask);
    assign adv_cand = {exp_reg[ACK_W-1:ROW_IW], {ROW_IW{1'b0}}} + ACK_W'(adv_z);
    assign adv_new  = (adv_cand < lim) ? adv_cand : lim;

    assign sc_base  = {idx_reg[ACK_W-1:ROW_IW], {ROW_IW{1'b0}}};
    assign sc_lt    = (idx_reg[ACK_W-1:ROW_IW] < high_id[ACK_W-1:ROW_IW]) ? '1 :
                      (idx_reg[ACK_W-1:ROW_IW] == high_id[ACK_W-1:ROW_IW]) ?
                      low_mask(high_reg[ROW_IW-1:0]) : '0;
    assign sc_cand  = ~ram_rdata & ~low_mask(idx_reg[ROW_IW-1:0]) & sc_lt;
    assign sc_f     = first_one(sc_cand);
    assign sc_found = !sc_f[ROW_IW];
    assign sc_id    = sc_base + ACK_W'(sc_f);
    assign l2_last  = ((idx_reg + 1'b1) == lim) || cap_hit;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        pid_next        = pid_reg;
        status_next     = status_reg;
        exp_next        = exp_reg;
        idx_next        = idx_reg;
        high_next       = high_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        done_next       = done_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        push            = 1'b0;
        push_data.kind     = KIND_NAK;
        push_data.status   = ST_BELOW;
        push_data.ack_no   = exp_reg;
        push_data.nak_id   = '0;
        push_data.msg_seq  = cnt_reg;
        push_data.last     = 1'b1;
        push_data.done_res = done_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = pid_id[ROW_IW +: RA];
        ram_wdata = ram_rdata | (ROW_BITS'(1) << pid_reg[ROW_IW-1:0]);
        ram_raddr = idx_reg[ROW_IW +: RA];

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == RA'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (request.action == ACT_ARRIVAL)
                    begin
                        pid_next = request.packet_id;
                        if (req_id < exp_reg)
                        begin
                            status_next = ST_BELOW;
                            state_next  = S_A_OUT;
                        end
                        else if (req_id >= MAP_LIM)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_A_OUT;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = req_id[ROW_IW +: RA];
                            state_next = S_A_CHK;
                        end
                    end
                    else if (done_reg)
                    begin
                        state_next = S_END_OUT;
                    end
                    else
                    begin
                        idx_next        = exp_reg;
                        n_next          = '0;
                        hold_valid_next = 1'b0;
                        state_next      = S_N_RD;
                    end
                end
            end
            S_A_CHK:
            begin
                if (chk_held)
                begin
                    status_next = ST_HELD;
                    state_next  = S_A_OUT;
                end
                else if (pid_id >= lim)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_A_OUT;
                end
                else
                begin
                    status_next = ST_STORED;
                    ram_we      = 1'b1;
                    if (pid_reg > high_reg)
                    begin
                        high_next = pid_reg;
                    end
                    state_next = S_ADV_RD;
                end
            end
            S_ADV_RD:
            begin
                if (exp_reg < lim)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = exp_reg[ROW_IW +: RA];
                    state_next = S_ADV_CHK;
                end
                else
                begin
                    state_next = S_A_OUT;
                end
            end
            S_ADV_CHK:
            begin
                exp_next = adv_new;
                if (adv_new == total_reg)
                begin
                    done_next = 1'b1;
                end
                if (adv_z[ROW_IW] && (adv_new < lim))
                begin
                    state_next = S_ADV_RD;
                end
                else
                begin
                    state_next = S_A_OUT;
                end
            end
            S_A_OUT:
            begin
                if (out_free)
                begin
                    push              = 1'b1;
                    push_data.kind    = KIND_STATUS;
                    push_data.status  = status_reg;
                    push_data.msg_seq = '0;
                    state_next        = S_IDLE;
                end
            end
            S_END_OUT:
            begin
                if (out_free)
                begin
                    push           = 1'b1;
                    push_data.kind = KIND_END;
                    cnt_next       = cnt_reg + 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_N_RD:
            begin
                if (idx_reg < high_id)
                begin
                    ram_re     = 1'b1;
                    state_next = S_N_SRCH;
                end
                else
                begin
                    state_next = S_N_END;
                end
            end
            S_N_SRCH:
            begin
                if (sc_found)
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            push             = 1'b1;
                            push_data.nak_id = hold_reg;
                            push_data.last   = 1'b0;
                        end
                        hold_next       = sc_id[ID_W-1:0];
                        hold_valid_next = 1'b1;
                        n_next          = n_inc;
                        idx_next        = sc_id + 1'b1;
                        if (cap_hit)
                        begin
                            state_next = S_N_END;
                        end
                        else if (sc_f == (ROW_IW + 1)'(ROW_BITS - 1))
                        begin
                            state_next = S_N_RD;
                        end
                    end
                end
                else
                begin
                    idx_next   = sc_base + ACK_W'(ROW_BITS);
                    state_next = S_N_RD;
                end
            end
            S_N_END:
            begin
                if (hold_valid_reg)
                begin
                    if (out_free)
                    begin
                        push             = 1'b1;
                        push_data.nak_id = hold_reg;
                        cnt_next         = cnt_reg + 1'b1;
                        hold_valid_next  = 1'b0;
                        state_next       = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = exp_reg;
                    n_next     = '0;
                    state_next = S_L2;
                end
            end
            S_L2:
            begin
                if (idx_reg >= lim)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    push             = 1'b1;
                    push_data.nak_id = idx_reg[ID_W-1:0];
                    push_data.last   = l2_last;
                    idx_next         = idx_reg + 1'b1;
                    n_next           = n_inc;
                    if (l2_last)
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            exp_reg        <= '0;
            high_reg       <= '0;
            hold_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            cnt_reg        <= '0;
            n_reg          <= '0;
            total_reg      <= ACK_W'(1);
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            exp_reg        <= exp_next;
            high_reg       <= high_next;
            hold_valid_reg <= hold_valid_next;
            done_reg       <= done_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            if (cfg_wr_en)
            begin
                total_reg <= cfg_wr_data;
            end
            if (push)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg    <= pid_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        hold_reg   <= hold_next;
        if (push)
        begin
            res_reg <= push_data;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.kind           = res_reg.kind;
    assign result.arrival_status = res_reg.status;
    assign result.ack_no         = res_reg.ack_no;
    assign result.nak_id         = res_reg.nak_id;
    assign result.msg_seq        = res_reg.msg_seq;
    assign result.last           = res_reg.last;
    assign result.done_res       = res_reg.done_res;

endmodule
